// File: sv/rsat_pkg.sv
// Types and constants shared by the recency-sorted address table modules.
package rsat_pkg;

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   localparam logic [2:0] STAT_ADDED     = 3'd0;
   localparam logic [2:0] STAT_REPLACED  = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_INVALID   = 3'd3;
   localparam logic [2:0] STAT_STALE     = 3'd4;
   localparam logic [2:0] STAT_READ_OK   = 3'd5;
   localparam logic [2:0] STAT_EMPTY_IDX = 3'd6;

   localparam logic [7:0] LOOPBACK_NET = 8'd127;

   typedef enum logic {
      ST_IDLE,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic        action;
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] seen_time;
      logic [7:0]  source;
      logic [1:0]  index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        is_new;
      logic [2:0]  entry_count;
      logic [31:0] read_ip;
      logic [15:0] read_port;
      logic [31:0] read_seen_time;
      logic [7:0]  read_source;
   } rsp_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] seen;
      logic [7:0]  source;
   } entry_type;

   typedef struct packed {
      logic match;
      logic older;
      logic stale;
   } cell_flags_type;

   typedef struct packed {
      logic apply;
      logic found;
      logic equal;
   } cell_ctrl_type;

endpackage

// File: sv/rsat_cell.sv
// One table position: holds an entry, compares it with the offered one and shifts with its neighbors.
module rsat_cell (
   input  logic                    clock,
   input  rsat_pkg::cell_ctrl_type ctrl,
   input  rsat_pkg::entry_type     new_entry,
   input  rsat_pkg::entry_type     left_entry,
   input  rsat_pkg::entry_type     right_entry,
   input  logic                    valid,
   input  logic                    thr_left,
   input  logic                    thr_right,
   input  logic                    match_in,
   output logic                    match_out,
   output logic                    thr_out,
   output rsat_pkg::cell_flags_type flags,
   output rsat_pkg::entry_type     entry_q
);
   import rsat_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      is_pos;
   logic      after_pos;
   logic      before_pos;
   logic      take_new;
   logic      take_left;
   logic      take_right;

   always_comb begin
      flags.match = valid && entry_ff.ip == new_entry.ip && entry_ff.port == new_entry.port;
      flags.older = valid && entry_ff.seen < new_entry.seen;
      flags.stale = flags.match && new_entry.seen < entry_ff.seen;
      thr_out     = !valid || flags.older;
      match_out   = match_in || flags.match;

      // The insert position sits one place earlier when an equal-time duplicate leaves a gap.
      if (ctrl.equal) begin
         is_pos     = thr_right && !thr_out;
         after_pos  = thr_out;
         before_pos = !thr_right;
      end else begin
         is_pos     = thr_out && !thr_left;
         after_pos  = thr_left;
         before_pos = !thr_out;
      end

      take_new   = is_pos;
      take_left  = after_pos && (!ctrl.found || !match_in);
      take_right = ctrl.found && match_out && before_pos;

      entry_in = entry_ff;
      if (take_new) begin
         entry_in = new_entry;
      end else if (take_left) begin
         entry_in = left_entry;
      end else if (take_right) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.apply) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_q = entry_ff;

endmodule

// File: sv/recency_sorted_address_table.sv
// Top level of the recency-sorted address table: request register, control and the row of cells.
//
//   Channel   Ports                     Handshake
//   request   start, busy, req          taken when start is high and busy is low
//   response  rsp_valid, rsp            one-cycle strobe, the receiver cannot stall
//
// Every transaction, update or read, passes from the accept cycle to an evaluation state in which all
// cells compare in parallel and, for an applied update, shift together; busy is high in the latter.
// The response strobes in the cycle after evaluation, while a new request may already be taken.
// Reset empties the table at once by clearing the entry count; no clearing pass is needed.
module recency_sorted_address_table #(
   parameter int TABLE_ENTRIES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rsat_pkg::req_type req,
   output logic              rsp_valid,
   output rsat_pkg::rsp_type rsp
);
   import rsat_pkg::*;

   localparam int CountWidth = $clog2(TABLE_ENTRIES + 1);
   localparam int ReadLimit  = (TABLE_ENTRIES < 4) ? TABLE_ENTRIES : 4;

   state_type               state_ff;
   state_type               state_in;
   req_type                 req_ff;
   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   entry_type               new_entry;
   entry_type               cell_q [TABLE_ENTRIES];
   cell_flags_type          cell_flags [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] cell_valid;
   logic [TABLE_ENTRIES-1:0] thr;
   logic [TABLE_ENTRIES:0]   match_chain;
   logic [TABLE_ENTRIES-1:0] match_vec;
   logic [TABLE_ENTRIES-1:0] older_match_vec;
   logic [TABLE_ENTRIES-1:0] stale_vec;
   cell_ctrl_type           ctrl;
   logic                    found;
   logic                    table_full;
   logic                    full_reject;
   logic                    invalid_addr;
   logic                    stale_dup;

   assign new_entry.ip     = req_ff.ip;
   assign new_entry.port   = req_ff.port;
   assign new_entry.seen   = req_ff.seen_time;
   assign new_entry.source = req_ff.source;
   assign match_chain[0]   = 1'b0;

   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      thr_left;
      logic      thr_right;

      if (k == 0) begin : g_first
         assign left_entry = new_entry;
         assign thr_left   = 1'b0;
      end else begin : g_inner_left
         assign left_entry = cell_q[k-1];
         assign thr_left   = thr[k-1];
      end

      if (k == TABLE_ENTRIES - 1) begin : g_last
         assign right_entry = new_entry;
         assign thr_right   = 1'b1;
      end else begin : g_inner_right
         assign right_entry = cell_q[k+1];
         assign thr_right   = thr[k+1];
      end

      assign cell_valid[k]      = CountWidth'(k) < count_ff;
      assign match_vec[k]       = cell_flags[k].match;
      assign older_match_vec[k] = cell_flags[k].match && cell_flags[k].older;
      assign stale_vec[k]       = cell_flags[k].stale;

      rsat_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .valid       (cell_valid[k]),
         .thr_left    (thr_left),
         .thr_right   (thr_right),
         .match_in    (match_chain[k]),
         .match_out   (match_chain[k+1]),
         .thr_out     (thr[k]),
         .flags       (cell_flags[k]),
         .entry_q     (cell_q[k])
      );
   end

   always_comb begin
      found        = |match_vec;
      stale_dup    = |stale_vec;
      table_full   = count_ff == CountWidth'(TABLE_ENTRIES);
      full_reject  = table_full && !cell_flags[TABLE_ENTRIES-1].older;
      invalid_addr = req_ff.ip[31:24] == LOOPBACK_NET || req_ff.ip == 32'd0 ||
                     req_ff.port == 16'd0;
      ctrl.found   = found;
      ctrl.equal   = found && !(|older_match_vec) && !stale_dup;
      ctrl.apply   = 1'b0;

      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in       = ST_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_in         = '0;
            if (req_ff.action == ACT_UPDATE) begin
               if (full_reject) begin
                  rsp_in.status = STAT_FULL;
               end else if (invalid_addr) begin
                  rsp_in.status = STAT_INVALID;
               end else if (stale_dup) begin
                  rsp_in.status = STAT_STALE;
               end else begin
                  ctrl.apply = 1'b1;
                  if (found) begin
                     rsp_in.status = STAT_REPLACED;
                  end else begin
                     rsp_in.status = STAT_ADDED;
                     rsp_in.is_new = 1'b1;
                     if (!table_full) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
            end else begin
               rsp_in.status = STAT_EMPTY_IDX;
               for (int k = 0; k < ReadLimit; k++) begin
                  if (req_ff.index == 2'(k) && cell_valid[k]) begin
                     rsp_in.status         = STAT_READ_OK;
                     rsp_in.read_ip        = cell_q[k].ip;
                     rsp_in.read_port      = cell_q[k].port;
                     rsp_in.read_seen_time = cell_q[k].seen;
                     rsp_in.read_source    = cell_q[k].source;
                  end
               end
            end
            rsp_in.entry_count = 3'(count_in);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (start && !busy) begin
         req_ff <= req;
      end
   end

   assign busy      = state_ff == ST_EVAL;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_rsp_after_eval : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EVAL))
      else $error("Response strobe without a preceding evaluation cycle.");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(TABLE_ENTRIES))
      else $error("Entry count exceeds the table size.");

   a_new_is_added : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_new |-> rsp_ff.status == STAT_ADDED)
      else $error("New-address flag set on a transaction that did not add an entry.");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |=> $stable(count_ff))
      else $error("Entry count changed outside an evaluation cycle.");

endmodule
